@@ rtl/rldr_pkg.sv @@
// shared types and constants for the run-length and delta block reconstruction core
package rldr_pkg;

   localparam int BLOCK_SIDE = 16;
   localparam int IDX_W      = $clog2(BLOCK_SIDE);
   localparam int SYM_W      = 9;
   localparam int PIX_W      = 8;
   localparam int POS_W      = 4;
   localparam int CMD_W      = 2;

   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SYMBOL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

   localparam logic [SYM_W-1:0] RLE_MARKER_RESET = 9'd257;
   localparam logic [IDX_W-1:0] IDX_LAST         = IDX_W'(BLOCK_SIDE - 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SYM,
      PH_COUNT,
      PH_VALUE
   } phase_type;

   typedef struct packed {
      logic horiz;
      logic delta;
      logic rle;
   } flags_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] sym;
      flags_type        flags;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] pixel;
      logic             last;
   } pix_type;

   typedef struct packed {
      phase_type phase;
      logic      full;
      logic      run_pending;
   } status_type;

   function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] v);
      return POS_W'(v);
   endfunction

endpackage

@@ rtl/block_rle_delta_reconstruct_core.sv @@
// top level of the run-length and delta block reconstruction core
//
//  port group  direction  tdata / tuser contents (low bit first)
//  req_*       in         tuser: command[1:0]; tdata: symbol[8:0], rle[9], delta[10], horiz[11]
//  rsp_*       out        tdata: pixel[7:0], row[11:8], column[15:12]; tlast: last pixel
//  csr_*       in         csr_wr_data: run marker[8:0]
//
//  one item per cycle sustained while the rsp side does not stall; req accept to rsp_tvalid passes
//  through the input register and the result register around one add and counter step
//  reset clears the open block, the counters and sets the run marker to 257
//  a stalled rsp side holds the result; req stays ready while the input register can move
module block_rle_delta_reconstruct_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // symbol, rle, delta, horiz, zero pad
   input  logic [rldr_pkg::CMD_W-1:0] req_tuser,   // command
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // pixel, row, column
   output logic                       rsp_tlast,
   input  logic                       csr_wr_en,
   input  logic [rldr_pkg::SYM_W-1:0] csr_wr_data
);
   import rldr_pkg::*;

   logic             in_valid_ff, in_valid_in;
   item_type         item_ff;
   logic [SYM_W-1:0] marker_ff;
   logic             adv;
   logic             emit;
   pix_type          pix;
   pix_type          out_pix;
   status_type       status;
   logic             req_take;

   assign req_take    = req_tvalid && req_tready;
   assign adv         = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready  = !in_valid_ff || adv;
   assign in_valid_in = req_take || (in_valid_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         marker_ff   <= RLE_MARKER_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            marker_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd         <= req_tuser;
         item_ff.sym         <= req_tdata[SYM_W-1:0];
         item_ff.flags.rle   <= req_tdata[SYM_W];
         item_ff.flags.delta <= req_tdata[SYM_W+1];
         item_ff.flags.horiz <= req_tdata[SYM_W+2];
      end
   end

   rldr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .item       (item_ff),
      .marker     (marker_ff),
      .emit       (emit),
      .pix        (pix),
      .status     (status)
   );

   rldr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .emit      (emit),
      .pix       (pix),
      .take      (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_pix   (out_pix)
   );

   assign rsp_tdata = {out_pix.column, out_pix.row, out_pix.pixel};
   assign rsp_tlast = out_pix.last;

`ifndef SYNTHESIS
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff))
      else $error("result appeared without a processed item");

   a_full_clears_on_start: assert property (@(posedge clock) disable iff (reset)
      $fell(status.full) |-> $past(adv && item_ff.cmd == CMD_START))
      else $error("full block reopened without a start item");

   a_idle_symbol_silent: assert property (@(posedge clock) disable iff (reset)
      (adv && item_ff.cmd == CMD_SYMBOL && status.phase == PH_IDLE) |=> !rsp_tvalid)
      else $error("symbol with no open block produced a pixel");

   a_pending_run_blocks_symbol: assert property (@(posedge clock) disable iff (reset)
      (adv && item_ff.cmd == CMD_SYMBOL && status.run_pending) |-> !emit)
      else $error("symbol taken while a run was pending");
`endif

endmodule

@@ rtl/rldr_ctrl.sv @@
// block state, run-length phase tracking and pixel generation for one item
module rldr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  rldr_pkg::item_type       item,
   input  logic [rldr_pkg::SYM_W-1:0] marker,
   output logic                     emit,
   output rldr_pkg::pix_type        pix,
   output rldr_pkg::status_type     status
);
   import rldr_pkg::*;

   phase_type        phase_ff, phase_in;
   flags_type        flags_ff, flags_in;
   logic [SYM_W-1:0] run_rem_ff, run_rem_in;
   logic [SYM_W-1:0] run_held_ff, run_held_in;
   logic [PIX_W-1:0] run_val_ff, run_val_in;
   logic [PIX_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0] major_ff, major_in;
   logic [IDX_W-1:0] minor_ff, minor_in;
   logic             full_ff, full_in;

   logic             want;
   logic [PIX_W-1:0] want_val;
   logic [PIX_W-1:0] sum;
   logic             at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         flags_ff    <= '0;
         run_rem_ff  <= '0;
         run_held_ff <= '0;
         run_val_ff  <= '0;
         acc_ff      <= '0;
         major_ff    <= '0;
         minor_ff    <= '0;
         full_ff     <= 1'b0;
      end else if (adv) begin
         phase_ff    <= phase_in;
         flags_ff    <= flags_in;
         run_rem_ff  <= run_rem_in;
         run_held_ff <= run_held_in;
         run_val_ff  <= run_val_in;
         acc_ff      <= acc_in;
         major_ff    <= major_in;
         minor_ff    <= minor_in;
         full_ff     <= full_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      flags_in    = flags_ff;
      run_rem_in  = run_rem_ff;
      run_held_in = run_held_ff;
      run_val_in  = run_val_ff;
      want        = 1'b0;
      want_val    = item.sym[PIX_W-1:0];
      unique case (item.cmd)
         CMD_START: begin
            flags_in    = item.flags;
            phase_in    = PH_SYM;
            run_rem_in  = '0;
            run_held_in = '0;
            run_val_in  = '0;
         end
         CMD_SYMBOL: begin
            if (phase_ff != PH_IDLE && run_rem_ff == '0 && !full_ff) begin
               if (!flags_ff.rle) begin
                  want = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_SYM: begin
                        if (item.sym == marker) begin
                           phase_in = PH_COUNT;
                        end else begin
                           want = 1'b1;
                        end
                     end
                     PH_COUNT: begin
                        run_held_in = item.sym;
                        phase_in    = PH_VALUE;
                     end
                     PH_VALUE: begin
                        run_val_in = item.sym[PIX_W-1:0];
                        run_rem_in = run_held_ff;
                        phase_in   = PH_SYM;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         CMD_DRAIN: begin
            if (run_rem_ff != '0) begin
               run_rem_in = run_rem_ff - 1'b1;
               want       = 1'b1;
               want_val   = run_val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign emit    = want && !full_ff;
   assign sum     = acc_ff + want_val;
   assign at_last = (major_ff == IDX_LAST) && (minor_ff == IDX_LAST);

   always_comb begin
      acc_in   = acc_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      full_in  = full_ff;
      if (item.cmd == CMD_START) begin
         acc_in   = '0;
         major_in = '0;
         minor_in = '0;
         full_in  = 1'b0;
      end else if (emit) begin
         if (flags_ff.delta) begin
            acc_in = sum;
         end
         if (at_last) begin
            full_in = 1'b1;
         end
         if (minor_ff == IDX_LAST) begin
            minor_in = '0;
            major_in = major_ff + 1'b1;
         end else begin
            minor_in = minor_ff + 1'b1;
         end
      end
   end

   always_comb begin
      pix.pixel = flags_ff.delta ? sum : want_val;
      pix.last  = at_last;
      if (flags_ff.horiz) begin
         pix.row    = to_pos(major_ff);
         pix.column = to_pos(minor_ff);
      end else begin
         pix.row    = to_pos(minor_ff);
         pix.column = to_pos(major_ff);
      end
   end

   assign status.phase       = phase_ff;
   assign status.full        = full_ff;
   assign status.run_pending = (run_rem_ff != '0);

endmodule

@@ rtl/rldr_out.sv @@
// result register holding one pixel item until the downstream side takes it
module rldr_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              emit,
   input  rldr_pkg::pix_type pix,
   input  logic              take,
   output logic              out_valid,
   output rldr_pkg::pix_type out_pix
);
   import rldr_pkg::*;

   logic    valid_ff;
   pix_type pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= emit;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         pix_ff <= pix;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

endmodule
